### design/lsb_first_bit_packer_varint_core_assert.svh
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_varint_core_assert.svh
// assertion macros used by the lbpv_back accumulator
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_PACKER_VARINT_CORE_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_VARINT_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LBPV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbpv assertion failed");

// next-cycle implication, disabled during reset
`define LBPV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbpv assertion failed");

`endif

### design/lbpv_pkg.sv
// ----------------------------------------------------------------------------
// lbpv_pkg
// types and constants shared by the bit packer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbpv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int IN_W           = 32;
  localparam int VALS_W         = 40;   // five varint groups of eight bits
  localparam int NGRP           = VALS_W / 8;
  localparam int ACC_W          = VALS_W + 7;
  localparam int CNT_W          = 6;
  localparam int GROUP_BITS     = 7;
  localparam int MAX_BYTES      = 4;
  localparam int FIFO_DEPTH     = 2;

  typedef enum logic [1:0] {
    MODE_BITS   = 2'd0,
    MODE_BYTES  = 2'd1,
    MODE_VARINT = 2'd2,
    MODE_FLUSH  = 2'd3
  } mode_t;

  // bit run handed from front to back: optional close, then nbits of vals
  typedef struct packed {
    logic              close;
    logic [CNT_W-1:0]  nbits;
    logic [VALS_W-1:0] vals;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } out_word_t;

endpackage

`default_nettype wire

### design/lbpv_fifo.sv
// ----------------------------------------------------------------------------
// lbpv_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbpv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lbpv_pkg::FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/lbpv_front.sv
// ----------------------------------------------------------------------------
// lbpv_front
// turns one request into a bit run: close flag, bit count and bit values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbpv_front #(
  parameter int DATA_WIDTH = lbpv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic [1:0]                  mode,
  input  wire logic [lbpv_pkg::CNT_W-1:0]  count,
  input  wire logic [lbpv_pkg::IN_W-1:0]   data,
  output lbpv_pkg::cmd_t                   cmd
);

  localparam int IN_W   = lbpv_pkg::IN_W;
  localparam int CNT_W  = lbpv_pkg::CNT_W;
  localparam int VALS_W = lbpv_pkg::VALS_W;
  localparam int GB     = lbpv_pkg::GROUP_BITS;
  localparam int EFF    = (DATA_WIDTH < IN_W) ? DATA_WIDTH : IN_W;
  localparam logic [IN_W-1:0]  DMASK = {IN_W{1'b1}} >> (IN_W - EFF);
  localparam logic [CNT_W-1:0] EFF_C = CNT_W'(EFF);
  localparam logic [CNT_W-1:0] IN_C  = CNT_W'(IN_W);

  logic [IN_W-1:0]  data_m;
  logic [CNT_W-1:0] nb;
  logic [IN_W-1:0]  bmask;
  logic [2:0]       nbytes;
  logic [2:0]       ngrp;
  logic [VALS_W-1:0] d_ext;
  logic [VALS_W-1:0] vint;
  lbpv_pkg::mode_t  m;

  assign data_m = data & DMASK;
  assign d_ext  = {{(VALS_W-IN_W){1'b0}}, data_m};
  assign m      = lbpv_pkg::mode_t'(mode);

  // bit-count saturation and mask
  assign nb    = (count > EFF_C) ? EFF_C : count;
  assign bmask = {IN_W{1'b1}} >> (IN_C - nb);

  assign nbytes = (count > CNT_W'(lbpv_pkg::MAX_BYTES)) ? 3'(lbpv_pkg::MAX_BYTES)
                                                         : count[2:0];

  // varint groups with continuation bit
  always_comb begin
    logic [GB-1:0] grp;
    logic          more;
    vint = '0;
    for (int i = 0; i < lbpv_pkg::NGRP; i++) begin
      grp  = d_ext[GB*i +: GB];
      more = |(d_ext >> (GB*(i+1)));
      vint[8*i +: 8] = {more, grp};
    end
  end

  always_comb begin
    if (|d_ext[VALS_W-1:4*GB]) begin
      ngrp = 3'd5;
    end else if (|d_ext[4*GB-1:3*GB]) begin
      ngrp = 3'd4;
    end else if (|d_ext[3*GB-1:2*GB]) begin
      ngrp = 3'd3;
    end else if (|d_ext[2*GB-1:GB]) begin
      ngrp = 3'd2;
    end else begin
      ngrp = 3'd1;
    end
  end

  always_comb begin
    cmd = '0;
    case (m)
      lbpv_pkg::MODE_BITS: begin
        cmd.close = 1'b0;
        cmd.nbits = nb;
        cmd.vals  = {{(VALS_W-IN_W){1'b0}}, data_m & bmask};
      end
      lbpv_pkg::MODE_BYTES: begin
        cmd.close = 1'b1;
        cmd.nbits = {nbytes, 3'b000};
        // first stream byte is the most significant one written
        case (nbytes)
          3'd1:    cmd.vals[7:0]  = data_m[7:0];
          3'd2:    cmd.vals[15:0] = {data_m[7:0], data_m[15:8]};
          3'd3:    cmd.vals[23:0] = {data_m[7:0], data_m[15:8], data_m[23:16]};
          3'd4:    cmd.vals[31:0] = {data_m[7:0], data_m[15:8], data_m[23:16],
                                     data_m[31:24]};
          default: cmd.vals = '0;
        endcase
      end
      lbpv_pkg::MODE_VARINT: begin
        cmd.close = 1'b0;
        cmd.nbits = {ngrp, 3'b000};
        cmd.vals  = vint;
      end
      lbpv_pkg::MODE_FLUSH: begin
        cmd.close = 1'b1;
        cmd.nbits = '0;
        cmd.vals  = '0;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/lbpv_back.sv
// ----------------------------------------------------------------------------
// lbpv_back
// bit accumulator: merges runs with the partial byte; unless ob_full, emits one byte a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_first_bit_packer_varint_core_assert.svh"

module lbpv_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_empty,
  input  wire lbpv_pkg::cmd_t      cmd,
  output logic                     cmd_pop,
  input  wire logic                ob_full,
  output logic                     ob_push,
  output lbpv_pkg::out_word_t      ob_word
);

  localparam int ACC_W  = lbpv_pkg::ACC_W;
  localparam int CNT_W  = lbpv_pkg::CNT_W;
  localparam int VALS_W = lbpv_pkg::VALS_W;

  // acc holds the pending bits, total their number; below 8 it is the partial byte
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] total_next;

  logic             emit;
  logic             last_byte;
  logic [CNT_W-1:0] total_m8;
  logic [6:0]       base_bits;
  logic [2:0]       base_cnt;
  logic [ACC_W-1:0] vals_ext;
  logic [ACC_W-1:0] bits_ext;

  assign emit      = (total >= CNT_W'(8)) && !ob_full;
  assign last_byte = (total < CNT_W'(16));
  assign total_m8  = total - CNT_W'(8);
  assign cmd_pop   = !cmd_empty && ((total < CNT_W'(8)) || (emit && last_byte));

  // partial byte left over once this cycle's byte is gone
  assign base_bits = emit ? acc[14:8] : acc[6:0];
  assign base_cnt  = emit ? total_m8[2:0] : total[2:0];
  assign vals_ext  = {{(ACC_W-VALS_W){1'b0}}, cmd.vals};
  assign bits_ext  = {{(ACC_W-7){1'b0}}, base_bits};

  assign ob_push           = emit;
  assign ob_word.data_byte = acc[7:0];
  assign ob_word.last      = last_byte;

  always_comb begin
    acc_next   = acc;
    total_next = total;
    if (cmd_pop) begin
      if (cmd.close) begin
        if (base_cnt != 3'd0) begin
          acc_next   = (vals_ext << 8) | bits_ext;
          total_next = cmd.nbits + CNT_W'(8);
        end else begin
          acc_next   = vals_ext;
          total_next = cmd.nbits;
        end
      end else begin
        acc_next   = (vals_ext << base_cnt) | bits_ext;
        total_next = cmd.nbits + {{(CNT_W-3){1'b0}}, base_cnt};
      end
    end else if (emit) begin
      acc_next   = acc >> 8;
      total_next = total_m8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      total <= '0;
    end else begin
      acc   <= acc_next;
      total <= total_next;
    end
  end

  `LBPV_ASSERT_NOW(a_pop_at_end, clk, rst, cmd_pop, total < CNT_W'(16))
  `LBPV_ASSERT_NEXT(a_last_leaves_partial, clk, rst, ob_push && ob_word.last && !cmd_pop,
    total < CNT_W'(8))
  `LBPV_ASSERT_NEXT(a_more_follows, clk, rst, ob_push && !ob_word.last,
    total >= CNT_W'(8))
  `LBPV_ASSERT_NEXT(a_stall_holds, clk, rst, (total >= CNT_W'(8)) && ob_full,
    $stable(acc) && $stable(total))

endmodule

`default_nettype wire

### design/lsb_first_bit_packer_varint_core.sv
// path: each request passes the command queue, back accumulator and result queue
// output: the back accumulator emits one byte a cycle while the result queue has room;
//   a new request loads while the last byte leaves
// reset: synchronous rst empties both queues and clears the partial byte
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_varint_core
// lsb-first bit packer with aligned big-endian bytes and leb128-style varints
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsb_first_bit_packer_varint_core #(
  parameter int DATA_WIDTH = lbpv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  mode,
  input  wire logic [lbpv_pkg::CNT_W-1:0]  count,
  input  wire logic [lbpv_pkg::IN_W-1:0]   data,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [7:0]                       out_byte,
  output logic                             last
);

  lbpv_pkg::cmd_t      cmd_in;
  lbpv_pkg::cmd_t      cmd_out;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                ob_full;
  logic                ob_push;
  lbpv_pkg::out_word_t ob_word;
  lbpv_pkg::out_word_t ob_head;

  lbpv_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .mode  (mode),
    .count (count),
    .data  (data),
    .cmd   (cmd_in)
  );

  lbpv_fifo #(
    .WIDTH($bits(lbpv_pkg::cmd_t)),
    .DEPTH(lbpv_pkg::FIFO_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  lbpv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .ob_full   (ob_full),
    .ob_push   (ob_push),
    .ob_word   (ob_word)
  );

  lbpv_fifo #(
    .WIDTH($bits(lbpv_pkg::out_word_t)),
    .DEPTH(lbpv_pkg::FIFO_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (ob_push),
    .din   (ob_word),
    .full  (ob_full),
    .pop   (pop),
    .dout  (ob_head),
    .empty (empty)
  );

  assign out_byte = ob_head.data_byte;
  assign last     = ob_head.last;

endmodule

`default_nettype wire

### test/lsb_first_bit_packer_varint_core_test.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_varint_core_test
// drives bit runs, aligned bytes, varints and flushes through the packer and
// checks each byte and last flag against typed bytes or a local bit-level model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_first_bit_packer_varint_core_test;

  localparam int ITEMS       = 320;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] value;
    logic       fin;
  } stream_byte_t;

  // one request word; typed rows carry their bytes, first byte in the top 8 bits
  typedef struct packed {
    lbpv_pkg::mode_t op;
    logic [5:0]      cnt;
    logic [31:0]     val;
    logic            typed;
    logic [2:0]      nexp;
    logic [39:0]     bytes;
  } stim_row_t;

  logic        clk  = 1'b0;
  logic        rst  = 1'b1;
  logic        push = 1'b0;
  logic        pop  = 1'b0;
  logic [1:0]  mode = '0;
  logic [5:0]  count = '0;
  logic [31:0] data = '0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        last;

  // model state: the unfinished byte
  logic [6:0]   pend_bits = '0;
  logic [2:0]   pend_cnt  = '0;
  logic [7:0]   run_q[$];
  stream_byte_t stream_q[$];
  stim_row_t    rows[$];
  int           errors      = 0;
  int           idle_cycles = 0;
  int           burst_left  = 0;
  bit           hold_req    = 1'b0;

  lsb_first_bit_packer_varint_core u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .count    (count),
    .data     (data),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void append_bits(logic [31:0] v, int nbits);
    logic [39:0] vals;
    logic [39:0] acc;
    int          total;
    vals  = {8'd0, v} & ((40'd1 << nbits) - 40'd1);
    acc   = {33'd0, pend_bits} | (vals << pend_cnt);
    total = pend_cnt + nbits;
    while (total >= 8) begin
      run_q.push_back(acc[7:0]);
      acc   = acc >> 8;
      total = total - 8;
    end
    pend_bits = acc[6:0];
    pend_cnt  = total[2:0];
  endfunction

  function automatic void close_byte();
    if (pend_cnt != 0) run_q.push_back({1'b0, pend_bits});
    pend_bits = '0;
    pend_cnt  = '0;
  endfunction

  // bytes one request word produces, left in run_q
  function automatic void pack_word(lbpv_pkg::mode_t op, logic [5:0] cnt, logic [31:0] d);
    int          nb;
    int          k;
    logic [31:0] rest;
    logic [7:0]  grp;
    run_q.delete();
    case (op)
      lbpv_pkg::MODE_BITS: begin
        nb = (cnt > 6'd32) ? 32 : cnt;
        append_bits(d, nb);
      end
      lbpv_pkg::MODE_BYTES: begin
        nb = (cnt > 6'd4) ? 4 : cnt;
        close_byte();
        for (k = nb; k > 0; k--) run_q.push_back(d[8*(k-1) +: 8]);
      end
      lbpv_pkg::MODE_VARINT: begin
        rest = d;
        do begin
          grp  = {1'b0, rest[6:0]};
          rest = rest >> 7;
          if (rest != 0) grp[7] = 1'b1;
          append_bits({24'd0, grp}, 8);
        end while (rest != 0);
      end
      default: close_byte();
    endcase
  endfunction

  function automatic void add_row(lbpv_pkg::mode_t op, logic [5:0] cnt, logic [31:0] val,
                                  logic typed, logic [2:0] nexp, logic [39:0] bytes);
    stim_row_t r;
    r.op    = op;
    r.cnt   = cnt;
    r.val   = val;
    r.typed = typed;
    r.nexp  = nexp;
    r.bytes = bytes;
    rows.push_back(r);
  endfunction

  task automatic send_word(input stim_row_t r);
    int           gap;
    int           roll;
    int           k;
    stream_byte_t sb;
    roll = $urandom_range(0, 99);
    if (hold_req || burst_left > 0) gap = 0;
    else if (roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    mode  <= r.op;
    count <= r.cnt;
    data  <= r.val;
    do @(posedge clk); while (full);
    pack_word(r.op, r.cnt, r.val);
    if (r.typed) begin
      run_q.delete();
      for (k = 0; k < r.nexp; k++) run_q.push_back(r.bytes[39-8*k -: 8]);
    end
    for (k = 0; k < run_q.size(); k++) begin
      sb.value = run_q[k];
      sb.fin   = (k == run_q.size() - 1);
      stream_q.push_back(sb);
    end
  endtask

  // stop offering and wait for every pending byte
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    wait (stream_q.size() == 0);
  endtask

  always @(posedge clk) begin : check_stream
    stream_byte_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        if (stream_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got %02h last %0b",
                   $time, out_byte, last);
        end else begin
          want = stream_q.pop_front();
          if (out_byte !== want.value) begin
            errors++;
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want.value, out_byte);
          end
          if (last !== want.fin) begin
            errors++;
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.fin, last);
          end
        end
      end
    end
  end

  initial begin : result_side
    int roll;
    wait (!rst);
    forever begin
      if (hold_req) begin
        // long hold-off so the packer backs up and raises full
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          pop <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (roll < 90) begin
          pop <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          pop <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL lsb_first_bit_packer_varint_core");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   r;
    int          i;
    int          roll;
    int          w;
    logic [63:0] mask;

    // rows with bytes typed in: aligned stream, extremes, saturation
    add_row(lbpv_pkg::MODE_BYTES, 6'd4, 32'h11223344, 1'b1, 3'd4, 40'h11223344_00);
    // nothing pending
    add_row(lbpv_pkg::MODE_FLUSH, 6'd0, 32'h00000000, 1'b1, 3'd0, 40'h0);
    // zero bit count
    add_row(lbpv_pkg::MODE_BITS, 6'd0, 32'hFFFFFFFF, 1'b1, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd8, 32'h000000A5, 1'b1, 3'd1, 40'hA5_00000000);
    add_row(lbpv_pkg::MODE_VARINT, 6'd0, 32'h00000000, 1'b1, 3'd1, 40'h00_00000000);
    add_row(lbpv_pkg::MODE_VARINT, 6'd63, 32'hFFFFFFFF, 1'b1, 3'd5, 40'hFFFFFFFF_0F);
    // close only, aligned
    add_row(lbpv_pkg::MODE_BYTES, 6'd0, 32'hDEADBEEF, 1'b1, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BYTES, 6'd63, 32'hCAFEF00D, 1'b1, 3'd4, 40'hCAFEF00D_00);
    add_row(lbpv_pkg::MODE_BITS, 6'd63, 32'h12345678, 1'b1, 3'd4, 40'h78563412_00);
    // unaligned cases, checked against the model
    add_row(lbpv_pkg::MODE_BITS, 6'd3, 32'hFFFFFFFD, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_FLUSH, 6'd63, 32'hFFFFFFFF, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd1, 32'h00000001, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BYTES, 6'd0, 32'h00000000, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd5, 32'h0000001F, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd32, 32'hFFFFFFFF, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_VARINT, 6'd0, 32'h0000007F, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_VARINT, 6'd63, 32'h00000080, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_VARINT, 6'd5, 32'h12345678, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd7, 32'h0000007F, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BYTES, 6'd2, 32'h0000ABCD, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd4, 32'h00000000, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BYTES, 6'd1, 32'h00000080, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd6, 32'h0000002A, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_FLUSH, 6'd0, 32'h00000000, 1'b0, 3'd0, 40'h0);
    add_row(lbpv_pkg::MODE_BITS, 6'd31, 32'h80000000, 1'b0, 3'd0, 40'h0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) send_word(rows[i]);
    settle();

    for (i = 0; i < ITEMS; i++) begin
      if (i == 100) hold_req = 1'b1;
      if (i == 200) settle();
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 30);
      r.typed = 1'b0;
      r.nexp  = '0;
      r.bytes = '0;
      r.val   = $urandom;
      // narrow values half the time so every varint length shows up
      if ($urandom_range(0, 1) == 1) begin
        w     = $urandom_range(0, 32);
        mask  = (64'd1 << w) - 64'd1;
        r.val = r.val & mask[31:0];
      end
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        r.op = lbpv_pkg::MODE_BITS;
        roll = $urandom_range(0, 9);
        if (roll == 0) r.cnt = 6'd0;
        else if (roll == 1) r.cnt = 6'($urandom_range(33, 63));
        else r.cnt = 6'($urandom_range(1, 32));
      end else if (roll < 6) begin
        r.op = lbpv_pkg::MODE_BYTES;
        if ($urandom_range(0, 9) < 8) r.cnt = 6'($urandom_range(0, 4));
        else r.cnt = 6'($urandom_range(5, 63));
      end else if (roll < 9) begin
        r.op  = lbpv_pkg::MODE_VARINT;
        r.cnt = 6'($urandom_range(0, 63));
      end else begin
        r.op  = lbpv_pkg::MODE_FLUSH;
        r.cnt = 6'($urandom_range(0, 63));
      end
      send_word(r);
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0 && stream_q.size() == 0) begin
      $display("PASS lsb_first_bit_packer_varint_core");
    end else begin
      $display("FAIL lsb_first_bit_packer_varint_core");
    end
    $finish;
  end

endmodule
